/* sv/ppcd_pkg.sv */
// Shared widths, reset values, register indexes and datapath command types
// for the planar pull PID coil drive. Depends on nothing.
package ppcd_pkg;

	localparam int COORD_BITS_DEF = 11;

	localparam int GAIN_W     = 16;
	localparam int SCALE_W    = 24;
	localparam int E_W        = 16;
	localparam int SUM_W      = 32;
	localparam int DIFF_W     = E_W + 1;
	localparam int OUT_W      = 16;
	localparam int AMAG_W     = 39;
	localparam int SPLIT      = 20;
	localparam int COIL_SHIFT = 24;
	localparam int QUOT_W     = 15;
	localparam int NUM_SHIFT  = 4;
	localparam int ACC_W      = 64;
	localparam int MA_W       = 33;
	localparam int MB_W       = 25;
	localparam int PROD_W     = MA_W + MB_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 16'd2560;
	localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = 16'd0;
	localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = 16'd0;
	localparam logic [SCALE_W-1:0] X_SCALE_RST    = 24'd8830;
	localparam logic [SCALE_W-1:0] Y_SCALE_RST    = 24'd12906;

	localparam logic [AMAG_W-1:0] AMAG_MAX      = '1;
	localparam logic [OUT_W-1:0]  DRIVE_POS_MAX = 16'h7FFF;
	localparam logic [OUT_W-1:0]  DRIVE_NEG_MIN = 16'h8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROP_GAIN  = 3'd0,
		CFG_INTEG_GAIN = 3'd1,
		CFG_DERIV_GAIN = 3'd2,
		CFG_X_SCALE    = 3'd3,
		CFG_Y_SCALE    = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		MA_E, MA_SUM, MA_DIFF, MA_AMAG_LO, MA_AMAG_HI,
		MA_MX_LO, MA_MX_HI, MA_MY_LO, MA_MY_HI
	} mul_a_t;

	typedef enum logic [2:0] {
		MB_PG, MB_IG, MB_DG, MB_XS, MB_YS, MB_ADX, MB_ADY
	} mul_b_t;

	typedef enum logic [2:0] {
		ACC_HOLD, ACC_CLR, ACC_LOAD, ACC_ADD, ACC_ADD_SH
	} acc_op_t;

	typedef struct packed {
		logic    load_in;
		logic    sq_en;
		logic    rt_step;
		logic    pid_en;
		logic    mag_en;
		logic    mx_en;
		logic    my_en;
		logic    numx_en;
		logic    numy_en;
		logic    div_init;
		logic    div_step;
		logic    res_load;
		mul_a_t  a_sel;
		mul_b_t  b_sel;
		acc_op_t acc_op;
	} dp_cmd_t;

endpackage

/* sv/ppcd_coord_if.sv */
// Input channel carrying robot and target pixel positions.
// Depends on ppcd_pkg.
interface ppcd_coord_if #(parameter int COORD_BITS = ppcd_pkg::COORD_BITS_DEF);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] robot_x;
	logic [COORD_BITS-1:0] robot_y;
	logic [COORD_BITS-1:0] target_x;
	logic [COORD_BITS-1:0] target_y;

	modport source (output valid, robot_x, robot_y, target_x, target_y, input ready);
	modport sink (input valid, robot_x, robot_y, target_x, target_y, output ready);
endinterface

/* sv/ppcd_drive_if.sv */
// Output channel carrying the four coil drives and the distance error.
// Depends on ppcd_pkg.
interface ppcd_drive_if;
	logic                               valid;
	logic                               ready;
	logic signed [ppcd_pkg::OUT_W-1:0]  drive_x_pos;
	logic signed [ppcd_pkg::OUT_W-1:0]  drive_x_neg;
	logic signed [ppcd_pkg::OUT_W-1:0]  drive_y_pos;
	logic signed [ppcd_pkg::OUT_W-1:0]  drive_y_neg;
	logic        [ppcd_pkg::E_W-1:0]    distance_error;

	modport source (output valid, drive_x_pos, drive_x_neg, drive_y_pos, drive_y_neg,
		distance_error, input ready);
	modport sink (input valid, drive_x_pos, drive_x_neg, drive_y_pos, drive_y_neg,
		distance_error, output ready);
endinterface

/* sv/ppcd_cfg_if.sv */
// Configuration write channel: register index and write data.
// Depends on ppcd_pkg.
interface ppcd_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [ppcd_pkg::CFG_IDX_W-1:0]      index;
	logic [ppcd_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/ppcd_ctrl.sv */
// Controller state machine: sequences the square root, PID, scaling and
// division steps of the datapath. Depends on ppcd_pkg.
module ppcd_ctrl #(
	parameter int COORD_BITS = ppcd_pkg::COORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output ppcd_pkg::dp_cmd_t cmd
);
	import ppcd_pkg::*;

	localparam int ROOT_W = COORD_BITS + 5;
	localparam int STEPS  = (ROOT_W > QUOT_W) ? ROOT_W : QUOT_W;
	localparam int CNT_W  = $clog2(STEPS);

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQ, ST_SQRT, ST_PID, ST_M_P, ST_M_I, ST_M_D, ST_M_W, ST_MAG,
		ST_X_LO, ST_X_HI, ST_X_W, ST_X_ST, ST_Y_LO, ST_Y_HI, ST_Y_W, ST_Y_ST,
		ST_NX_LO, ST_NX_HI, ST_NX_W, ST_NX_ST, ST_NY_LO, ST_NY_HI, ST_NY_W, ST_NY_ST,
		ST_DIV_INIT, ST_DIV, ST_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		cmd.a_sel  = MA_E;
		cmd.b_sel  = MB_PG;
		cmd.acc_op = ACC_HOLD;
		case (state_q)
			ST_IDLE: cmd.load_in = in_valid;
			ST_SQ: cmd.sq_en = 1'b1;
			ST_SQRT: cmd.rt_step = 1'b1;
			ST_PID: begin
				cmd.pid_en = 1'b1;
				cmd.acc_op = ACC_CLR;
			end
			ST_M_P: begin
				cmd.a_sel = MA_E;
				cmd.b_sel = MB_PG;
			end
			ST_M_I: begin
				cmd.a_sel  = MA_SUM;
				cmd.b_sel  = MB_IG;
				cmd.acc_op = ACC_ADD;
			end
			ST_M_D: begin
				cmd.a_sel  = MA_DIFF;
				cmd.b_sel  = MB_DG;
				cmd.acc_op = ACC_ADD;
			end
			ST_M_W: cmd.acc_op = ACC_ADD;
			ST_MAG: cmd.mag_en = 1'b1;
			ST_X_LO: begin
				cmd.a_sel = MA_AMAG_LO;
				cmd.b_sel = MB_XS;
			end
			ST_X_HI: begin
				cmd.a_sel  = MA_AMAG_HI;
				cmd.b_sel  = MB_XS;
				cmd.acc_op = ACC_LOAD;
			end
			ST_X_W: cmd.acc_op = ACC_ADD_SH;
			ST_X_ST: cmd.mx_en = 1'b1;
			ST_Y_LO: begin
				cmd.a_sel = MA_AMAG_LO;
				cmd.b_sel = MB_YS;
			end
			ST_Y_HI: begin
				cmd.a_sel  = MA_AMAG_HI;
				cmd.b_sel  = MB_YS;
				cmd.acc_op = ACC_LOAD;
			end
			ST_Y_W: cmd.acc_op = ACC_ADD_SH;
			ST_Y_ST: cmd.my_en = 1'b1;
			ST_NX_LO: begin
				cmd.a_sel = MA_MX_LO;
				cmd.b_sel = MB_ADX;
			end
			ST_NX_HI: begin
				cmd.a_sel  = MA_MX_HI;
				cmd.b_sel  = MB_ADX;
				cmd.acc_op = ACC_LOAD;
			end
			ST_NX_W: cmd.acc_op = ACC_ADD_SH;
			ST_NX_ST: cmd.numx_en = 1'b1;
			ST_NY_LO: begin
				cmd.a_sel = MA_MY_LO;
				cmd.b_sel = MB_ADY;
			end
			ST_NY_HI: begin
				cmd.a_sel  = MA_MY_HI;
				cmd.b_sel  = MB_ADY;
				cmd.acc_op = ACC_LOAD;
			end
			ST_NY_W: cmd.acc_op = ACC_ADD_SH;
			ST_NY_ST: cmd.numy_en = 1'b1;
			ST_DIV_INIT: cmd.div_init = 1'b1;
			ST_DIV: cmd.div_step = 1'b1;
			ST_FIN: cmd.res_load = slot_free;
			default: cmd.acc_op = ACC_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && slot_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_SQ;
				ST_SQ: begin
					cnt_q   <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (cnt_q == CNT_W'(ROOT_W - 1)) begin
						state_q <= ST_PID;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_PID:    state_q <= ST_M_P;
				ST_M_P:    state_q <= ST_M_I;
				ST_M_I:    state_q <= ST_M_D;
				ST_M_D:    state_q <= ST_M_W;
				ST_M_W:    state_q <= ST_MAG;
				ST_MAG:    state_q <= ST_X_LO;
				ST_X_LO:   state_q <= ST_X_HI;
				ST_X_HI:   state_q <= ST_X_W;
				ST_X_W:    state_q <= ST_X_ST;
				ST_X_ST:   state_q <= ST_Y_LO;
				ST_Y_LO:   state_q <= ST_Y_HI;
				ST_Y_HI:   state_q <= ST_Y_W;
				ST_Y_W:    state_q <= ST_Y_ST;
				ST_Y_ST:   state_q <= ST_NX_LO;
				ST_NX_LO:  state_q <= ST_NX_HI;
				ST_NX_HI:  state_q <= ST_NX_W;
				ST_NX_W:   state_q <= ST_NX_ST;
				ST_NX_ST:  state_q <= ST_NY_LO;
				ST_NY_LO:  state_q <= ST_NY_HI;
				ST_NY_HI:  state_q <= ST_NY_W;
				ST_NY_W:   state_q <= ST_NY_ST;
				ST_NY_ST:  state_q <= ST_DIV_INIT;
				ST_DIV_INIT: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(QUOT_W - 1)) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* sv/ppcd_dp.sv */
// Datapath: configuration registers, bit-serial square root, shared multiplier
// with accumulator, two-lane restoring divider and result register. Depends on ppcd_pkg.
module ppcd_dp #(
	parameter int COORD_BITS = ppcd_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ppcd_pkg::dp_cmd_t                   cmd,
	input  logic                                cfg_we,
	input  logic [ppcd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ppcd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [COORD_BITS-1:0]               robot_x,
	input  logic [COORD_BITS-1:0]               robot_y,
	input  logic [COORD_BITS-1:0]               target_x,
	input  logic [COORD_BITS-1:0]               target_y,
	output logic signed [ppcd_pkg::OUT_W-1:0]   drive_x_pos,
	output logic signed [ppcd_pkg::OUT_W-1:0]   drive_x_neg,
	output logic signed [ppcd_pkg::OUT_W-1:0]   drive_y_pos,
	output logic signed [ppcd_pkg::OUT_W-1:0]   drive_y_neg,
	output logic        [ppcd_pkg::E_W-1:0]     distance_error
);
	import ppcd_pkg::*;

	localparam int ROOT_W = COORD_BITS + 5;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int SQ_W   = 2 * COORD_BITS + 1;
	localparam int REM_W  = ROOT_W + 3;
	localparam int NUM_W  = AMAG_W + COORD_BITS + NUM_SHIFT;
	localparam int OVC_W  = NUM_W - QUOT_W;

	function automatic logic [2*OUT_W-1:0] steer(input logic ovf,
		input logic [QUOT_W-1:0] q, input logic neg);
		logic [OUT_W-1:0] mag;
		mag = OUT_W'(q);
		if (neg && (ovf || (q != '0))) begin
			if (ovf)
				return {{OUT_W{1'b0}}, DRIVE_NEG_MIN};
			return {{OUT_W{1'b0}}, OUT_W'(-mag)};
		end
		if (ovf)
			return {DRIVE_POS_MAX, {OUT_W{1'b0}}};
		return {mag, {OUT_W{1'b0}}};
	endfunction

	logic [GAIN_W-1:0]  prop_gain_q, integ_gain_q, deriv_gain_q;
	logic [SCALE_W-1:0] x_scale_q, y_scale_q;
	logic [SUM_W-1:0]   error_sum_q;
	logic [E_W-1:0]     prev_error_q;

	logic [COORD_BITS-1:0] adx_q, ady_q;
	logic                  dx_neg_q, dy_neg_q;
	logic [RAD_W-1:0]      rad_q;
	logic [REM_W-1:0]      rt_rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [E_W-1:0]        e_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [AMAG_W-1:0]     amag_q, mx_q, my_q;
	logic                  acc_neg_q;
	logic [NUM_W-1:0]      num_q [2];
	logic [ROOT_W-1:0]     dv_rem_q [2];
	logic [QUOT_W-1:0]     nlow_q [2];
	logic [QUOT_W-1:0]     quo_q [2];
	logic                  ovf_q [2];

	logic signed [COORD_BITS:0] dx_c, dy_c;
	logic [COORD_BITS-1:0] adx_c, ady_c;
	logic [SQ_W-1:0]       adx_w, ady_w, sq_c;
	logic [REM_W-1:0]      rt_cur, rt_trial;
	logic [31:0]           ef32;
	logic [E_W-1:0]        e_c;
	logic [SUM_W:0]        sum_wide;
	logic [SUM_W-1:0]      sum_c;
	logic signed [DIFF_W-1:0] diff_c;
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [ACC_W-1:0] prod_ext;
	logic [ACC_W-1:0]      acc_abs;
	logic [ROOT_W:0]       dv_cur [2];
	logic                  dv_ge [2];
	logic [OVC_W-1:0]      num_hi [2];
	logic                  ef_zero;
	logic                  x_ovf, y_ovf, x_neg, y_neg;
	logic [QUOT_W-1:0]     x_q, y_q;
	logic [2*OUT_W-1:0]    x_drv, y_drv;

	always_comb begin
		dx_c  = $signed({1'b0, target_x}) - $signed({1'b0, robot_x});
		dy_c  = $signed({1'b0, target_y}) - $signed({1'b0, robot_y});
		adx_c = dx_c[COORD_BITS] ? COORD_BITS'(-dx_c) : dx_c[COORD_BITS-1:0];
		ady_c = dy_c[COORD_BITS] ? COORD_BITS'(-dy_c) : dy_c[COORD_BITS-1:0];
		adx_w = SQ_W'(adx_q);
		ady_w = SQ_W'(ady_q);
		sq_c  = adx_w * adx_w + ady_w * ady_w;

		rt_cur   = {rt_rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		rt_trial = {1'b0, root_q, 2'b01};

		ef32     = 32'(root_q);
		e_c      = (ef32 > 32'h0000_FFFF) ? '1 : ef32[E_W-1:0];
		sum_wide = {1'b0, error_sum_q} + (SUM_W+1)'(e_c);
		sum_c    = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
		diff_c   = $signed({1'b0, e_c}) - $signed({1'b0, prev_error_q});

		case (cmd.a_sel)
			MA_E:       mul_a = $signed(MA_W'(e_q));
			MA_SUM:     mul_a = $signed(MA_W'(error_sum_q));
			MA_DIFF:    mul_a = MA_W'(diff_q);
			MA_AMAG_LO: mul_a = $signed(MA_W'(amag_q[SPLIT-1:0]));
			MA_AMAG_HI: mul_a = $signed(MA_W'(amag_q[AMAG_W-1:SPLIT]));
			MA_MX_LO:   mul_a = $signed(MA_W'(mx_q[SPLIT-1:0]));
			MA_MX_HI:   mul_a = $signed(MA_W'(mx_q[AMAG_W-1:SPLIT]));
			MA_MY_LO:   mul_a = $signed(MA_W'(my_q[SPLIT-1:0]));
			MA_MY_HI:   mul_a = $signed(MA_W'(my_q[AMAG_W-1:SPLIT]));
			default:    mul_a = '0;
		endcase
		case (cmd.b_sel)
			MB_PG:   mul_b = $signed(MB_W'(prop_gain_q));
			MB_IG:   mul_b = $signed(MB_W'(integ_gain_q));
			MB_DG:   mul_b = $signed(MB_W'(deriv_gain_q));
			MB_XS:   mul_b = $signed(MB_W'(x_scale_q));
			MB_YS:   mul_b = $signed(MB_W'(y_scale_q));
			MB_ADX:  mul_b = $signed(MB_W'(adx_q));
			MB_ADY:  mul_b = $signed(MB_W'(ady_q));
			default: mul_b = '0;
		endcase

		prod_ext = ACC_W'(prod_q);
		acc_abs  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);

		for (int l = 0; l < 2; l++) begin
			dv_cur[l] = {dv_rem_q[l], nlow_q[l][QUOT_W-1]};
			dv_ge[l]  = dv_cur[l] >= {1'b0, root_q};
			num_hi[l] = num_q[l][NUM_W-1:QUOT_W];
		end

		ef_zero = (root_q == '0);
		if (ef_zero) begin
			x_ovf = |mx_q[AMAG_W-1:QUOT_W];
			x_q   = mx_q[QUOT_W-1:0];
			x_neg = acc_neg_q;
			y_ovf = 1'b0;
			y_q   = '0;
			y_neg = 1'b0;
		end else begin
			x_ovf = ovf_q[0];
			x_q   = quo_q[0];
			x_neg = acc_neg_q ^ dx_neg_q;
			y_ovf = ovf_q[1];
			y_q   = quo_q[1];
			y_neg = acc_neg_q ^ dy_neg_q;
		end
		x_drv = steer(x_ovf, x_q, x_neg);
		y_drv = steer(y_ovf, y_q, y_neg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= PROP_GAIN_RST;
			integ_gain_q <= INTEG_GAIN_RST;
			deriv_gain_q <= DERIV_GAIN_RST;
			x_scale_q    <= X_SCALE_RST;
			y_scale_q    <= Y_SCALE_RST;
			error_sum_q  <= '0;
			prev_error_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_PROP_GAIN:  prop_gain_q  <= cfg_data[GAIN_W-1:0];
					CFG_INTEG_GAIN: integ_gain_q <= cfg_data[GAIN_W-1:0];
					CFG_DERIV_GAIN: deriv_gain_q <= cfg_data[GAIN_W-1:0];
					CFG_X_SCALE:    x_scale_q    <= cfg_data[SCALE_W-1:0];
					CFG_Y_SCALE:    y_scale_q    <= cfg_data[SCALE_W-1:0];
					default:        prop_gain_q  <= prop_gain_q;
				endcase
			end
			if (cmd.pid_en) begin
				error_sum_q  <= sum_c;
				prev_error_q <= e_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			adx_q    <= adx_c;
			ady_q    <= ady_c;
			dx_neg_q <= dx_c[COORD_BITS];
			dy_neg_q <= dy_c[COORD_BITS];
		end
		if (cmd.sq_en) begin
			rad_q    <= RAD_W'({sq_c, 8'b0});
			rt_rem_q <= '0;
			root_q   <= '0;
		end
		if (cmd.rt_step) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (rt_cur >= rt_trial) begin
				rt_rem_q <= rt_cur - rt_trial;
				root_q   <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rt_rem_q <= rt_cur;
				root_q   <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.pid_en) begin
			e_q    <= e_c;
			diff_q <= diff_c;
		end

		prod_q <= mul_a * mul_b;
		case (cmd.acc_op)
			ACC_CLR:    acc_q <= '0;
			ACC_LOAD:   acc_q <= prod_ext;
			ACC_ADD:    acc_q <= acc_q + prod_ext;
			ACC_ADD_SH: acc_q <= acc_q + (prod_ext <<< SPLIT);
			default:    acc_q <= acc_q;
		endcase

		if (cmd.mag_en) begin
			acc_neg_q <= acc_q[ACC_W-1];
			amag_q    <= (acc_abs > ACC_W'(AMAG_MAX)) ? AMAG_MAX : acc_abs[AMAG_W-1:0];
		end
		if (cmd.mx_en)
			mx_q <= acc_q[COIL_SHIFT +: AMAG_W];
		if (cmd.my_en)
			my_q <= acc_q[COIL_SHIFT +: AMAG_W];
		if (cmd.numx_en)
			num_q[0] <= {acc_q[NUM_W-NUM_SHIFT-1:0], {NUM_SHIFT{1'b0}}};
		if (cmd.numy_en)
			num_q[1] <= {acc_q[NUM_W-NUM_SHIFT-1:0], {NUM_SHIFT{1'b0}}};

		for (int l = 0; l < 2; l++) begin
			if (cmd.div_init) begin
				ovf_q[l]    <= num_hi[l] >= OVC_W'(root_q);
				dv_rem_q[l] <= num_hi[l][ROOT_W-1:0];
				nlow_q[l]   <= num_q[l][QUOT_W-1:0];
				quo_q[l]    <= '0;
			end
			if (cmd.div_step) begin
				dv_rem_q[l] <= dv_ge[l] ? ROOT_W'(dv_cur[l] - {1'b0, root_q})
					: dv_cur[l][ROOT_W-1:0];
				nlow_q[l]   <= {nlow_q[l][QUOT_W-2:0], 1'b0};
				quo_q[l]    <= {quo_q[l][QUOT_W-2:0], dv_ge[l]};
			end
		end

		if (cmd.res_load) begin
			drive_x_pos    <= x_drv[2*OUT_W-1:OUT_W];
			drive_x_neg    <= x_drv[OUT_W-1:0];
			drive_y_pos    <= y_drv[2*OUT_W-1:OUT_W];
			drive_y_neg    <= y_drv[OUT_W-1:0];
			distance_error <= e_q;
		end
	end

endmodule

/* sv/planar_pull_pid_coil_drive.sv */
// Channel   Direction  Payload
// coords    in         robot_x, robot_y, target_x, target_y
// drive     out        drive_x_pos, drive_x_neg, drive_y_pos, drive_y_neg, distance_error
// cfg       in         index, data (register write)
//
// One item runs from acceptance to the next acceptance through the one-bit-per-cycle
// square root, the 15-step divider and the shared multiplier sequence for the PID
// and scaling; no new item is accepted until the controller is idle again.
// The result waits in an output register, so a stalled sink holds only the final step.
// Reset clears the controller, error sum and previous error, and returns the gain
// and scale registers to their defaults.
// Configuration writes are always taken.
// Top level of the planar pull PID coil drive; depends on ppcd_pkg, the
// channel interfaces, ppcd_ctrl and ppcd_dp.
module planar_pull_pid_coil_drive #(
	parameter int COORD_BITS = ppcd_pkg::COORD_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	ppcd_coord_if.sink  coords,
	ppcd_drive_if.source drive,
	ppcd_cfg_if.sink    cfg
);
	import ppcd_pkg::*;

	dp_cmd_t cmd;

	assign cfg.ready = 1'b1;

	ppcd_ctrl #(.COORD_BITS(COORD_BITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (coords.valid),
		.in_ready  (coords.ready),
		.out_valid (drive.valid),
		.out_ready (drive.ready),
		.cmd       (cmd)
	);

	ppcd_dp #(.COORD_BITS(COORD_BITS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_we         (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.robot_x        (coords.robot_x),
		.robot_y        (coords.robot_y),
		.target_x       (coords.target_x),
		.target_y       (coords.target_y),
		.drive_x_pos    (drive.drive_x_pos),
		.drive_x_neg    (drive.drive_x_neg),
		.drive_y_pos    (drive.drive_y_pos),
		.drive_y_neg    (drive.drive_y_neg),
		.distance_error (drive.distance_error)
	);

endmodule
